// ----- hw/rtl/lps_pkg.sv -----
package lps_pkg;

  localparam int COORD_BITS_DEFAULT = 12;
  localparam int BYTE_BITS          = 8;
  localparam int OFFSET_BITS        = 26;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 14;

  localparam int MENU_W   = 12;
  localparam int SCREEN_W = 12;
  localparam int PBITS_W  = 6;
  localparam int STRIDE_W = 14;
  localparam int BPP_W    = PBITS_W - 3;

  localparam logic [CFG_INDEX_W-1:0] REG_MENU_BAND_WIDTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_BITS       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_STRIDE_BYTES = 3'd4;

  localparam logic [MENU_W-1:0]   MENU_RESET   = 12'd250;
  localparam logic [SCREEN_W-1:0] WIDTH_RESET  = 12'd1920;
  localparam logic [SCREEN_W-1:0] HEIGHT_RESET = 12'd1080;
  localparam logic [PBITS_W-1:0]  PBITS_RESET  = 6'd32;
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 14'd7680;

  typedef struct packed {
    logic [MENU_W-1:0]   menu_band_width;
    logic [SCREEN_W-1:0] screen_width;
    logic [SCREEN_W-1:0] screen_height;
    logic [PBITS_W-1:0]  pixel_bits;
    logic [STRIDE_W-1:0] row_stride_bytes;
  } cfg_t;

endpackage

// ----- hw/rtl/lps_cfg.sv -----
module lps_cfg
  import lps_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.menu_band_width  <= MENU_RESET;
      cfg.screen_width     <= WIDTH_RESET;
      cfg.screen_height    <= HEIGHT_RESET;
      cfg.pixel_bits       <= PBITS_RESET;
      cfg.row_stride_bytes <= STRIDE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MENU_BAND_WIDTH:  cfg.menu_band_width  <= cfg_data[MENU_W-1:0];
        REG_SCREEN_WIDTH:     cfg.screen_width     <= cfg_data[SCREEN_W-1:0];
        REG_SCREEN_HEIGHT:    cfg.screen_height    <= cfg_data[SCREEN_W-1:0];
        REG_PIXEL_BITS:       cfg.pixel_bits       <= cfg_data[PBITS_W-1:0];
        REG_ROW_STRIDE_BYTES: cfg.row_stride_bytes <= cfg_data[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/lps_stepper.sv -----
module lps_stepper
  import lps_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cfg_t                         cfg,
  input  logic                         take,
  input  logic                         adv,
  input  logic                         mode,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  output logic                         res_valid,
  output logic                         res_pixel_valid,
  output logic        [COORD_BITS-1:0] res_x,
  output logic        [COORD_BITS-1:0] res_y,
  output logic                         res_inside,
  output logic                         res_last,
  output logic                         res_done
);

  localparam int SPAN_W = COORD_BITS + 1;
  localparam int ERR_W  = COORD_BITS + 3;
  localparam int E2_W   = COORD_BITS + 4;
  localparam int CMP_W  = (COORD_BITS > SCREEN_W ? COORD_BITS : SCREEN_W) + 1;

  logic signed [COORD_BITS-1:0] current_x, current_y, target_x, target_y;
  logic        [SPAN_W-1:0]     span_x, span_y;
  logic                         step_left_x, step_up_y, line_active;
  logic signed [ERR_W-1:0]      error_term;

  logic signed [SPAN_W-1:0]     dx, dy;
  logic        [SPAN_W-1:0]     span_x_load, span_y_load;
  logic signed [ERR_W-1:0]      err_load;

  logic signed [E2_W-1:0]       e2, neg_sy, pos_sx;
  logic                         move_x, move_y;
  logic signed [ERR_W-1:0]      error_next;
  logic signed [COORD_BITS-1:0] current_x_next, current_y_next;
  logic                         active_next;

  logic signed [CMP_W-1:0]      x_cmp, y_cmp, menu_cmp, width_cmp, height_cmp;
  logic                         in_window;

  always_comb begin
    dx = SPAN_W'(end_x) - SPAN_W'(start_x);
    dy = SPAN_W'(end_y) - SPAN_W'(start_y);
    span_x_load = dx[SPAN_W-1] ? SPAN_W'(-dx) : SPAN_W'(dx);
    span_y_load = dy[SPAN_W-1] ? SPAN_W'(-dy) : SPAN_W'(dy);
    err_load = $signed({2'b00, span_x_load}) - $signed({2'b00, span_y_load});

    e2     = {error_term, 1'b0};
    neg_sy = -$signed({3'b000, span_y});
    pos_sx = $signed({3'b000, span_x});
    move_x = e2 > neg_sy;
    move_y = e2 < pos_sx;

    error_next     = error_term;
    current_x_next = current_x;
    current_y_next = current_y;
    if (move_x) begin
      error_next     = error_next - $signed({2'b00, span_y});
      current_x_next = step_left_x ? current_x - 1'b1 : current_x + 1'b1;
    end
    if (move_y) begin
      error_next     = error_next + $signed({2'b00, span_x});
      current_y_next = step_up_y ? current_y - 1'b1 : current_y + 1'b1;
    end
    active_next = !((current_x_next == target_x) && (current_y_next == target_y));

    x_cmp      = {{(CMP_W-COORD_BITS){current_x[COORD_BITS-1]}}, current_x};
    y_cmp      = {{(CMP_W-COORD_BITS){current_y[COORD_BITS-1]}}, current_y};
    menu_cmp   = $signed({{(CMP_W-MENU_W){1'b0}}, cfg.menu_band_width});
    width_cmp  = $signed({{(CMP_W-SCREEN_W){1'b0}}, cfg.screen_width});
    height_cmp = $signed({{(CMP_W-SCREEN_W){1'b0}}, cfg.screen_height});
    in_window = (x_cmp >= menu_cmp) && (x_cmp < width_cmp) &&
                !y_cmp[CMP_W-1] && (y_cmp < height_cmp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_x   <= '0;
      current_y   <= '0;
      target_x    <= '0;
      target_y    <= '0;
      span_x      <= '0;
      span_y      <= '0;
      step_left_x <= 1'b0;
      step_up_y   <= 1'b0;
      error_term  <= '0;
      line_active <= 1'b0;
    end else if (take) begin
      if (!mode) begin
        span_x      <= span_x_load;
        span_y      <= span_y_load;
        step_left_x <= !(start_x < end_x);
        step_up_y   <= !(start_y < end_y);
        error_term  <= err_load;
        current_x   <= start_x;
        current_y   <= start_y;
        target_x    <= end_x;
        target_y    <= end_y;
        line_active <= (start_x != end_x) || (start_y != end_y);
      end else if (line_active) begin
        error_term  <= error_next;
        current_x   <= current_x_next;
        current_y   <= current_y_next;
        line_active <= active_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= take && mode;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_pixel_valid <= line_active;
      res_x           <= line_active ? current_x : '0;
      res_y           <= line_active ? current_y : '0;
      res_inside      <= line_active && in_window;
      res_last        <= line_active && !active_next;
      res_done        <= !line_active;
    end
  end

endmodule

// ----- hw/rtl/lps_addr.sv -----
module lps_addr
  import lps_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cfg_t                          cfg,
  input  logic                          load,
  input  logic                          res_valid,
  input  logic                          res_pixel_valid,
  input  logic         [COORD_BITS-1:0] res_x,
  input  logic         [COORD_BITS-1:0] res_y,
  input  logic                          res_inside,
  input  logic                          res_last,
  input  logic                          res_done,
  output logic                          out_valid,
  output logic                          pixel_valid,
  output logic signed  [COORD_BITS-1:0] pixel_x,
  output logic signed  [COORD_BITS-1:0] pixel_y,
  output logic                          inside_window,
  output logic        [OFFSET_BITS-1:0] byte_offset,
  output logic                          last_pixel,
  output logic                          line_done
);

  logic [BPP_W-1:0]               bytes_per_pixel;
  logic [COORD_BITS+BPP_W-1:0]    x_part;
  logic [COORD_BITS+STRIDE_W-1:0] y_part;
  logic [OFFSET_BITS-1:0]         offset;

  always_comb begin
    bytes_per_pixel = cfg.pixel_bits[PBITS_W-1:3];
    x_part = (COORD_BITS+BPP_W)'(res_x) * (COORD_BITS+BPP_W)'(bytes_per_pixel);
    y_part = (COORD_BITS+STRIDE_W)'(res_y) * (COORD_BITS+STRIDE_W)'(cfg.row_stride_bytes);
    offset = res_inside ? OFFSET_BITS'(x_part) + OFFSET_BITS'(y_part) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pixel_valid   <= res_pixel_valid;
      pixel_x       <= res_x;
      pixel_y       <= res_y;
      inside_window <= res_inside;
      byte_offset   <= offset;
      last_pixel    <= res_last;
      line_done     <= res_done;
    end
  end

endmodule

// ----- hw/rtl/line_pixel_stepper_core.sv -----
// A step request's result is registered first in the stepper's result stage, then in the address stage.
// Throughput: one request per cycle while in_stall is low; load requests give no result.
// The stepper state update and the offset multiply sit in separate stages.
// Reset clears the line state, empties both stages and restores the
// register defaults.
module line_pixel_stepper_core
  import lps_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic        [CFG_INDEX_W-1:0] cfg_index,
  input  logic        [CFG_DATA_W-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          mode,
  input  logic signed  [COORD_BITS-1:0] start_x,
  input  logic signed  [COORD_BITS-1:0] start_y,
  input  logic signed  [COORD_BITS-1:0] end_x,
  input  logic signed  [COORD_BITS-1:0] end_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          pixel_valid,
  output logic signed  [COORD_BITS-1:0] pixel_x,
  output logic signed  [COORD_BITS-1:0] pixel_y,
  output logic                          inside_window,
  output logic        [OFFSET_BITS-1:0] byte_offset,
  output logic                          last_pixel,
  output logic                          line_done
);

  cfg_t                  cfg;
  logic                  out_load, step_adv, take;
  logic                  res_valid, res_pixel_valid, res_inside, res_last, res_done;
  logic [COORD_BITS-1:0] res_x, res_y;

  assign out_load = !out_valid || !out_stall;
  assign step_adv = !res_valid || out_load;
  assign in_stall = !step_adv;
  assign take     = in_valid && step_adv;

  lps_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lps_stepper #(.COORD_BITS(COORD_BITS)) u_stepper (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .take            (take),
    .adv             (step_adv),
    .mode            (mode),
    .start_x         (start_x),
    .start_y         (start_y),
    .end_x           (end_x),
    .end_y           (end_y),
    .res_valid       (res_valid),
    .res_pixel_valid (res_pixel_valid),
    .res_x           (res_x),
    .res_y           (res_y),
    .res_inside      (res_inside),
    .res_last        (res_last),
    .res_done        (res_done)
  );

  lps_addr #(.COORD_BITS(COORD_BITS)) u_addr (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .load            (out_load),
    .res_valid       (res_valid),
    .res_pixel_valid (res_pixel_valid),
    .res_x           (res_x),
    .res_y           (res_y),
    .res_inside      (res_inside),
    .res_last        (res_last),
    .res_done        (res_done),
    .out_valid       (out_valid),
    .pixel_valid     (pixel_valid),
    .pixel_x         (pixel_x),
    .pixel_y         (pixel_y),
    .inside_window   (inside_window),
    .byte_offset     (byte_offset),
    .last_pixel      (last_pixel),
    .line_done       (line_done)
  );

endmodule

// ----- verif/tb_line_pixel_stepper_core.sv -----
module tb_line_pixel_stepper_core;
  import lps_pkg::*;

  localparam int CW = COORD_BITS_DEFAULT;
  localparam int CMAX = 2 ** (CW - 1) - 1;
  localparam int CMIN = -(2 ** (CW - 1));
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;
  localparam int DRAIN_LIMIT = 50000;
  localparam int TOTAL_REQUESTS = 1850;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    logic                   pixel_valid;
    logic [CW-1:0]          x;
    logic [CW-1:0]          y;
    logic                   in_win;
    logic [OFFSET_BITS-1:0] offset;
    logic                   last;
    logic                   done;
  } pixel_result_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic mode = 1'b0;
  coord_t start_x = '0;
  coord_t start_y = '0;
  coord_t end_x = '0;
  coord_t end_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic pixel_valid;
  coord_t pixel_x;
  coord_t pixel_y;
  logic inside_window;
  logic [OFFSET_BITS-1:0] byte_offset;
  logic last_pixel;
  logic line_done;

  cfg_t window;
  coord_t pen_x = '0;
  coord_t pen_y = '0;
  coord_t goal_x = '0;
  coord_t goal_y = '0;
  int span_x = 0;
  int span_y = 0;
  logic head_left = 1'b0;
  logic head_up = 1'b0;
  int bres_err = 0;
  logic drawing = 1'b0;

  pixel_result_t pixel_queue[$];

  bit sender_idle_en = 1'b0;
  bit receiver_idle_en = 1'b0;
  int hold_left = 0;
  int error_count = 0;
  int requests_sent = 0;
  int pixels_checked = 0;
  int empty_steps_checked = 0;
  int settings_applied = 0;

  line_pixel_stepper_core #(
    .COORD_BITS(CW)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .start_x(start_x),
    .start_y(start_y),
    .end_x(end_x),
    .end_y(end_y),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pixel_valid(pixel_valid),
    .pixel_x(pixel_x),
    .pixel_y(pixel_y),
    .inside_window(inside_window),
    .byte_offset(byte_offset),
    .last_pixel(last_pixel),
    .line_done(line_done)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic coord_t clamp_coord(input int v);
    if (v > CMAX) return coord_t'(CMAX);
    if (v < CMIN) return coord_t'(CMIN);
    return coord_t'(v);
  endfunction

  function automatic string describe(input pixel_result_t r);
    return $sformatf("valid=%0b x=%0d y=%0d in=%0b off=%0d last=%0b done=%0b",
                     r.pixel_valid, $signed(r.x), $signed(r.y), r.in_win, r.offset,
                     r.last, r.done);
  endfunction

  // Updates the shadow line state for one accepted request; a step request also queues its expected result.
  task automatic trace_request(input logic m, input coord_t sx, input coord_t sy,
                               input coord_t ex, input coord_t ey);
    pixel_result_t res;
    int x;
    int y;
    int e2;
    longint off;
    res = '0;
    if (m == MODE_LOAD) begin
      span_x = (ex > sx) ? int'(ex) - int'(sx) : int'(sx) - int'(ex);
      span_y = (ey > sy) ? int'(ey) - int'(sy) : int'(sy) - int'(ey);
      head_left = !(sx < ex);
      head_up = !(sy < ey);
      bres_err = span_x - span_y;
      pen_x = sx;
      pen_y = sy;
      goal_x = ex;
      goal_y = ey;
      drawing = (sx != ex) || (sy != ey);
    end else begin
      if (!drawing) begin
        res.done = 1'b1;
      end else begin
        x = pen_x;
        y = pen_y;
        res.pixel_valid = 1'b1;
        res.x = pen_x;
        res.y = pen_y;
        res.in_win = (x >= int'(window.menu_band_width)) && (x < int'(window.screen_width))
                     && (y >= 0) && (y < int'(window.screen_height));
        if (res.in_win) begin
          off = longint'(x) * (window.pixel_bits / BYTE_BITS)
                + longint'(y) * window.row_stride_bytes;
          res.offset = off[OFFSET_BITS-1:0];
        end
        e2 = 2 * bres_err;
        if (e2 > -span_y) begin
          bres_err -= span_y;
          pen_x = head_left ? coord_t'(pen_x - 1) : coord_t'(pen_x + 1);
        end
        if (e2 < span_x) begin
          bres_err += span_x;
          pen_y = head_up ? coord_t'(pen_y - 1) : coord_t'(pen_y + 1);
        end
        drawing = !(pen_x == goal_x && pen_y == goal_y);
        res.last = !drawing;
      end
      pixel_queue.push_back(res);
    end
  endtask

  task automatic issue_request(input logic m, input coord_t sx, input coord_t sy,
                               input coord_t ex, input coord_t ey);
    int gap;
    gap = sender_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    start_x <= sx;
    start_y <= sy;
    end_x <= ex;
    end_y <= ey;
    do @(posedge clk); while (in_stall);
    requests_sent++;
    trace_request(m, sx, sy, ex, ey);
  endtask

  task automatic load_line(input coord_t sx, input coord_t sy, input coord_t ex,
                           input coord_t ey);
    issue_request(MODE_LOAD, sx, sy, ex, ey);
  endtask

  task automatic step_pixel();
    issue_request(MODE_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom));
  endtask

  task automatic wait_for_idle();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pixel_queue.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_setting(input logic [CFG_INDEX_W-1:0] idx, input int value);
    logic [CFG_DATA_W-1:0] data;
    data = value[CFG_DATA_W-1:0];
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MENU_BAND_WIDTH: window.menu_band_width = data[MENU_W-1:0];
      REG_SCREEN_WIDTH: window.screen_width = data[SCREEN_W-1:0];
      REG_SCREEN_HEIGHT: window.screen_height = data[SCREEN_W-1:0];
      REG_PIXEL_BITS: window.pixel_bits = data[PBITS_W-1:0];
      REG_ROW_STRIDE_BYTES: window.row_stride_bytes = data[STRIDE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input int menu, input int wide, input int high,
                               input int pbits, input int stride);
    wait_for_idle();
    write_setting(REG_MENU_BAND_WIDTH, menu);
    write_setting(REG_SCREEN_WIDTH, wide);
    write_setting(REG_SCREEN_HEIGHT, high);
    write_setting(REG_PIXEL_BITS, pbits);
    write_setting(REG_ROW_STRIDE_BYTES, stride);
    write_setting(CFG_INDEX_W'(REG_ROW_STRIDE_BYTES + $urandom_range(1, 3)), $urandom);
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  task automatic test_empty_steps();
    repeat (2) step_pixel();
  endtask

  task automatic test_directed_lines();
    load_line(0, 0, 0, 0);
    step_pixel();
    load_line(300, 5, 303, 5);
    repeat (4) step_pixel();
    load_line(2047, 2047, -2048, -2048);
    repeat (2) step_pixel();
    load_line(-2048, -2048, 2047, 2047);
    repeat (2) step_pixel();
    load_line(1000, -1, 1000, -3);
    repeat (2) step_pixel();
    load_line(1919, 1079, 1921, 1081);
    repeat (2) step_pixel();
    load_line(250, 0, 249, 1);
    repeat (2) step_pixel();
    load_line(500, 500, 501, 503);
    repeat (3) step_pixel();
  endtask

  // Mostly whole lines started near the window edges; a few are cut short by a
  // new load, run past their end, or are replaced by stray requests.
  task automatic test_random_lines(input int quota);
    int stop_at;
    int r;
    int span;
    int dx;
    int dy;
    int len;
    int steps;
    int base;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    stop_at = requests_sent + quota;
    while (requests_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        issue_request(1'($urandom_range(0, 1)), coord_t'($urandom), coord_t'($urandom),
                      coord_t'($urandom), coord_t'($urandom));
      end else begin
        if ($urandom_range(0, 99) < 30) begin
          sx = coord_t'($urandom);
          sy = coord_t'($urandom);
        end else begin
          case ($urandom_range(0, 3))
            0: base = window.menu_band_width;
            1: base = window.screen_width;
            2: base = 0;
            default: base = $urandom_range(0, 2047);
          endcase
          sx = clamp_coord(base + int'($urandom_range(0, 12)) - 6);
          case ($urandom_range(0, 2))
            0: base = 0;
            1: base = window.screen_height;
            default: base = $urandom_range(0, 1200);
          endcase
          sy = clamp_coord(base + int'($urandom_range(0, 12)) - 6);
        end
        span = $urandom_range(0, 99);
        span = (span < 90) ? 12 : (span < 99) ? 120 : 1000;
        dx = int'($urandom_range(0, 2 * span)) - span;
        dy = int'($urandom_range(0, 2 * span)) - span;
        ex = clamp_coord(int'(sx) + dx);
        ey = clamp_coord(int'(sy) + dy);
        dx = int'(ex) - int'(sx);
        dy = int'(ey) - int'(sy);
        dx = (dx < 0) ? -dx : dx;
        dy = (dy < 0) ? -dy : dy;
        len = (dx > dy) ? dx : dy;
        load_line(sx, sy, ex, ey);
        if (r < 18) begin
          steps = $urandom_range(0, len);
        end else begin
          steps = len + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
        end
        repeat (steps) step_pixel();
      end
    end
  endtask

  task automatic test_register_settings();
    apply_setting(0, 1, 1, 8, 0);
    test_random_lines(100);
    sender_idle_en = 1'b0;
    receiver_idle_en = 1'b0;
    apply_setting(0, 4095, 4095, 32, 16383);
    test_random_lines(100);
    sender_idle_en = 1'b1;
    receiver_idle_en = 1'b1;
    apply_setting(4095, 4095, 4095, 63, 16383);
    test_random_lines(100);
    // Upper data bits beyond each register width must be dropped.
    apply_setting(14'h1007, 14'h1000, 14'h3014, 14'h0107, 100);
    test_random_lines(100);
    apply_setting(3, 640, 480, 12, 1280);
    test_random_lines(100);
    repeat (3) begin
      apply_setting($urandom_range(0, 400), $urandom_range(1, 2047), $urandom_range(1, 2047),
                    8 * $urandom_range(1, 4), $urandom);
      test_random_lines(110);
    end
  endtask

  // The receiver holds off long enough for the block to fill and stall requests.
  task automatic test_output_backpressure();
    wait_for_idle();
    sender_idle_en = 1'b0;
    load_line(300, 300, 340, 310);
    hold_left = 90;
    repeat (45) step_pixel();
    sender_idle_en = 1'b1;
    wait_for_idle();
  endtask

  initial begin : receiver
    int run_left;
    bit stalling;
    run_left = 0;
    stalling = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (!receiver_idle_en) begin
        out_stall <= 1'b0;
      end else begin
        if (run_left == 0) begin
          stalling = ($urandom_range(0, 2) == 0);
          run_left = stalling ? pick_gap() + 1 : $urandom_range(1, 12);
        end
        out_stall <= stalling;
        run_left--;
      end
    end
  end

  always @(posedge clk) begin : check_pixels
    pixel_result_t got;
    pixel_result_t want;
    if (!rst && out_valid && !out_stall) begin
      got = {pixel_valid, pixel_x, pixel_y, inside_window, byte_offset, last_pixel, line_done};
      if (pixel_queue.size() == 0) begin
        if (error_count < 10) $display("unexpected result: %s", describe(got));
        error_count++;
      end else begin
        want = pixel_queue.pop_front();
        if (got.pixel_valid !== want.pixel_valid || got.x !== want.x || got.y !== want.y
            || got.in_win !== want.in_win || got.offset !== want.offset
            || got.last !== want.last || got.done !== want.done) begin
          if (error_count < 10) begin
            $display("mismatch at %0t: expected %s", $realtime, describe(want));
            $display("                  actual %s", describe(got));
          end
          error_count++;
        end
        if (want.done) empty_steps_checked++;
        else pixels_checked++;
      end
    end
  end

  initial begin
    window = '{MENU_RESET, WIDTH_RESET, HEIGHT_RESET, PBITS_RESET, STRIDE_RESET};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_empty_steps();
    test_directed_lines();
    sender_idle_en = 1'b1;
    receiver_idle_en = 1'b1;
    test_random_lines(300);
    test_register_settings();
    test_output_backpressure();
    apply_setting($urandom_range(0, 300), $urandom_range(600, 2047), $urandom_range(400, 2047),
                  8 * $urandom_range(1, 4), $urandom);
    test_random_lines((requests_sent < TOTAL_REQUESTS - 100) ?
                      TOTAL_REQUESTS - requests_sent : 100);
    wait_for_idle();
    if (pixel_queue.size() != 0) begin
      $display("%0d expected results never arrived", pixel_queue.size());
      error_count++;
    end
    $display("Sent %0d requests; checked %0d pixels and %0d steps with no line.",
             requests_sent, pixels_checked, empty_steps_checked);
    $display("Used %0d register settings, output hold-off and input back-pressure.",
             settings_applied);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- line_pixel_stepper_core.f -----
hw/rtl/lps_pkg.sv
hw/rtl/lps_cfg.sv
hw/rtl/lps_stepper.sv
hw/rtl/lps_addr.sv
hw/rtl/line_pixel_stepper_core.sv
verif/tb_line_pixel_stepper_core.sv
